// ===== design/sdsp_pkg.sv =====
// Shared types, constants and helpers for the SD card SPI-mode command
// and block-read sequencer. No dependencies; every design file imports it.
`default_nettype none

package sdsp_pkg;

    localparam int BLOCK_BYTES    = 512;
    localparam int R1_FLUSH_BYTES = 1;
    localparam int MAX_RES        = 3;

    localparam int POLL_W     = 10;
    localparam int BYTE_CNT_W = $clog2(BLOCK_BYTES + 1);
    localparam int FLUSH_W    = 5;
    localparam int POS_W      = 3;
    localparam int RES_CNT_W  = 2;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = POLL_W'(100);

    localparam logic [7:0] CMD_PREFIX  = 8'h40;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [7:0] R1_OK       = 8'h00;
    localparam logic [5:0] CMD_READ_1  = 6'd17;
    localparam logic [POS_W-1:0] LAST_ARG_POS = POS_W'(5);

    // action codes carried on the slave-side tuser
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_RX   = 2'd2;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_FRAME = 4'd1,
        PH_POLL  = 4'd2,
        PH_FLUSH = 4'd3,
        PH_TOKEN = 4'd4,
        PH_DATA  = 4'd5,
        PH_CRC   = 4'd6
    } t_phase;

    // input word, first field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  rx_byte;
        logic [22:0] sector;
        logic [4:0]  flush_count;
        logic [7:0]  crc_byte;
        logic [31:0] argument;
        logic [5:0]  command_index;
    } t_in_word;

    // output word, first field in the lowest bits
    typedef struct packed {
        logic [6:0] pad;
        logic       timed_out;
        logic [7:0] status;
        logic [7:0] data_byte;
        logic [7:0] tx_byte;
    } t_out_word;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic [7:0] data_byte;
        logic [7:0] status;
        logic       timed_out;
        logic       last;
    } t_result;

    // all results caused by one input word
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]  cnt;
    } t_batch;

    function automatic t_result mk_res(t_kind kind, logic [7:0] tx, logic [7:0] data,
                                       logic [7:0] status, logic tmo);
        t_result r;
        r.kind      = kind;
        r.tx_byte   = tx;
        r.data_byte = data;
        r.status    = status;
        r.timed_out = tmo;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(logic [5:0] idx, logic [31:0] arg,
                                              logic [7:0] chk, logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            POS_W'(0): b = CMD_PREFIX | {2'b00, idx};
            POS_W'(1): b = arg[31:24];
            POS_W'(2): b = arg[23:16];
            POS_W'(3): b = arg[15:8];
            POS_W'(4): b = arg[7:0];
            default:   b = chk;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/sdsp_seq.sv =====
// Sequencer state and step logic: turns one registered input word into up
// to three results and the next state. Depends on sdsp_pkg.
`default_nettype none

module sdsp_seq (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_fire,
    input  wire [1:0]                i_action,
    input  sdsp_pkg::t_in_word       i_word,
    input  wire [sdsp_pkg::POLL_W-1:0] i_poll_limit,
    output sdsp_pkg::t_batch         o_batch,
    output logic                     o_idle
);
    import sdsp_pkg::*;

    t_phase                r_phase, n_phase;
    logic                  r_read_mode, n_read_mode;
    logic [BYTE_CNT_W-1:0] r_byte_counter, n_byte_counter;
    logic [POLL_W-1:0]     r_try_counter, n_try_counter;
    logic [POLL_W-1:0]     r_retry_counter, n_retry_counter;
    logic [5:0]            r_frame_index, n_frame_index;
    logic [31:0]           r_frame_argument, n_frame_argument;
    logic [7:0]            r_frame_check, n_frame_check;
    logic [FLUSH_W-1:0]    r_pending_flush, n_pending_flush;
    logic [7:0]            r_last_response, n_last_response;
    logic [POS_W-1:0]      r_frame_pos, n_frame_pos;

    t_result [MAX_RES-1:0] e_res;
    logic [RES_CNT_W-1:0]  e_cnt;
    logic                  do_end;
    logic                  do_begin;
    logic [7:0]            end_lr;
    logic [POLL_W-1:0]     limit;
    logic [POLL_W-1:0]     try_dec;
    logic [POLL_W-1:0]     retry_dec;
    logic [FLUSH_W-1:0]    flush_dec;
    logic [BYTE_CNT_W-1:0] byte_inc;

    assign limit     = (i_poll_limit == '0) ? POLL_W'(1) : i_poll_limit;
    assign try_dec   = r_try_counter - POLL_W'(1);
    assign retry_dec = r_retry_counter - POLL_W'(1);
    assign flush_dec = r_pending_flush - FLUSH_W'(1);
    assign byte_inc  = r_byte_counter + BYTE_CNT_W'(1);

    always_comb begin
        n_phase          = r_phase;
        n_read_mode      = r_read_mode;
        n_byte_counter   = r_byte_counter;
        n_try_counter    = r_try_counter;
        n_retry_counter  = r_retry_counter;
        n_frame_index    = r_frame_index;
        n_frame_argument = r_frame_argument;
        n_frame_check    = r_frame_check;
        n_pending_flush  = r_pending_flush;
        n_last_response  = r_last_response;
        n_frame_pos      = r_frame_pos;
        e_res            = '0;
        e_cnt            = '0;
        do_end           = 1'b0;
        do_begin         = 1'b0;
        end_lr           = r_last_response;

        case (i_action)
            ACT_CMD, ACT_READ: begin
                if (r_phase == PH_IDLE) begin
                    do_begin = 1'b1;
                    if (i_action == ACT_CMD) begin
                        n_read_mode      = 1'b0;
                        n_frame_index    = i_word.command_index;
                        n_frame_argument = i_word.argument;
                        n_frame_check    = i_word.crc_byte;
                        n_pending_flush  = i_word.flush_count;
                    end else begin
                        n_read_mode      = 1'b1;
                        n_frame_index    = CMD_READ_1;
                        n_frame_argument = {i_word.sector, 9'd0};
                        n_frame_check    = IDLE_BYTE;
                        n_retry_counter  = limit;
                    end
                end
            end
            ACT_RX: begin
                case (r_phase)
                    PH_FRAME: begin
                        if (r_frame_pos < LAST_ARG_POS) begin
                            n_frame_pos  = r_frame_pos + POS_W'(1);
                            e_res[e_cnt] = mk_res(KIND_TX, frame_byte(r_frame_index,
                                r_frame_argument, r_frame_check, n_frame_pos),
                                8'd0, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                        end else begin
                            n_phase       = PH_POLL;
                            n_try_counter = limit;
                            e_res[e_cnt]  = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                            e_cnt         = e_cnt + RES_CNT_W'(1);
                        end
                    end
                    PH_POLL: begin
                        n_last_response = i_word.rx_byte;
                        n_try_counter   = try_dec;
                        if (i_word.rx_byte != IDLE_BYTE || try_dec == '0) begin
                            e_res[e_cnt] = mk_res(KIND_RELEASE, 8'd0, 8'd0, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                            if (r_pending_flush != '0) begin
                                n_phase      = PH_FLUSH;
                                e_res[e_cnt] = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                                e_cnt        = e_cnt + RES_CNT_W'(1);
                            end else begin
                                do_end = 1'b1;
                                end_lr = i_word.rx_byte;
                            end
                        end else begin
                            e_res[e_cnt] = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                        end
                    end
                    PH_FLUSH: begin
                        if (!r_read_mode) begin
                            e_res[e_cnt] = mk_res(KIND_DATA, 8'd0, i_word.rx_byte, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                        end
                        n_pending_flush = flush_dec;
                        if (flush_dec != '0) begin
                            e_res[e_cnt] = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                        end else begin
                            e_res[e_cnt] = mk_res(KIND_RELEASE, 8'd0, 8'd0, 8'd0, 1'b0);
                            e_cnt        = e_cnt + RES_CNT_W'(1);
                            do_end       = 1'b1;
                        end
                    end
                    PH_TOKEN: begin
                        if (i_word.rx_byte == DATA_TOKEN) begin
                            n_phase        = PH_DATA;
                            n_byte_counter = '0;
                            e_res[e_cnt]   = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                            e_cnt          = e_cnt + RES_CNT_W'(1);
                        end else begin
                            n_try_counter = try_dec;
                            if (try_dec == '0) begin
                                // give up on the token: release select before done
                                n_phase      = PH_IDLE;
                                e_res[e_cnt] = mk_res(KIND_RELEASE, 8'd0, 8'd0, 8'd0, 1'b0);
                                e_cnt        = e_cnt + RES_CNT_W'(1);
                                e_res[e_cnt] = mk_res(KIND_DONE, 8'd0, 8'd0,
                                                      i_word.rx_byte, 1'b1);
                                e_cnt        = e_cnt + RES_CNT_W'(1);
                            end else begin
                                e_res[e_cnt] = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                                e_cnt        = e_cnt + RES_CNT_W'(1);
                            end
                        end
                    end
                    PH_DATA: begin
                        e_res[e_cnt]   = mk_res(KIND_DATA, 8'd0, i_word.rx_byte, 8'd0, 1'b0);
                        e_cnt          = e_cnt + RES_CNT_W'(1);
                        n_byte_counter = byte_inc;
                        if (byte_inc >= BYTE_CNT_W'(BLOCK_BYTES)) begin
                            n_phase        = PH_CRC;
                            n_byte_counter = '0;
                        end
                        e_res[e_cnt]   = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                        e_cnt          = e_cnt + RES_CNT_W'(1);
                    end
                    PH_CRC: begin
                        if (r_byte_counter == '0) begin
                            n_byte_counter = BYTE_CNT_W'(1);
                            e_res[e_cnt]   = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                            e_cnt          = e_cnt + RES_CNT_W'(1);
                        end else begin
                            n_phase        = PH_IDLE;
                            n_byte_counter = '0;
                            e_res[e_cnt]   = mk_res(KIND_RELEASE, 8'd0, 8'd0, 8'd0, 1'b0);
                            e_cnt          = e_cnt + RES_CNT_W'(1);
                            e_res[e_cnt]   = mk_res(KIND_DONE, 8'd0, 8'd0, R1_OK, 1'b0);
                            e_cnt          = e_cnt + RES_CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // wrap up a command: report, move on to the token, or retry the read
        if (do_end) begin
            if (!r_read_mode) begin
                n_phase      = PH_IDLE;
                e_res[e_cnt] = mk_res(KIND_DONE, 8'd0, 8'd0, end_lr, end_lr == IDLE_BYTE);
                e_cnt        = e_cnt + RES_CNT_W'(1);
            end else if (end_lr == R1_OK) begin
                n_phase       = PH_TOKEN;
                n_try_counter = limit;
                e_res[e_cnt]  = mk_res(KIND_TX, IDLE_BYTE, 8'd0, 8'd0, 1'b0);
                e_cnt         = e_cnt + RES_CNT_W'(1);
            end else begin
                n_retry_counter = retry_dec;
                if (retry_dec == '0) begin
                    n_phase      = PH_IDLE;
                    e_res[e_cnt] = mk_res(KIND_DONE, 8'd0, 8'd0, end_lr, 1'b1);
                    e_cnt        = e_cnt + RES_CNT_W'(1);
                end else begin
                    do_begin = 1'b1;
                end
            end
        end

        // start a frame with its command byte
        if (do_begin) begin
            n_phase      = PH_FRAME;
            n_frame_pos  = '0;
            if (n_read_mode) begin
                n_pending_flush = FLUSH_W'(R1_FLUSH_BYTES);
            end
            e_res[e_cnt] = mk_res(KIND_TX, frame_byte(n_frame_index, n_frame_argument,
                                  n_frame_check, POS_W'(0)), 8'd0, 8'd0, 1'b0);
            e_cnt        = e_cnt + RES_CNT_W'(1);
        end

        if (e_cnt != '0) begin
            e_res[e_cnt - RES_CNT_W'(1)].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_read_mode      <= 1'b0;
            r_byte_counter   <= '0;
            r_try_counter    <= '0;
            r_retry_counter  <= '0;
            r_frame_index    <= '0;
            r_frame_argument <= '0;
            r_frame_check    <= '0;
            r_pending_flush  <= '0;
            r_last_response  <= '0;
            r_frame_pos      <= '0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_read_mode      <= n_read_mode;
            r_byte_counter   <= n_byte_counter;
            r_try_counter    <= n_try_counter;
            r_retry_counter  <= n_retry_counter;
            r_frame_index    <= n_frame_index;
            r_frame_argument <= n_frame_argument;
            r_frame_check    <= n_frame_check;
            r_pending_flush  <= n_pending_flush;
            r_last_response  <= n_last_response;
            r_frame_pos      <= n_frame_pos;
        end
    end

    assign o_batch.res = e_res;
    assign o_batch.cnt = e_cnt;
    assign o_idle      = (r_phase == PH_IDLE);

endmodule

`default_nettype wire

// ===== design/sdsp_out_buf.sv =====
// Result register bank: holds the results of one step and hands them out
// one word per cycle in order while i_ready is high. Depends on sdsp_pkg.
`default_nettype none

module sdsp_out_buf (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  sdsp_pkg::t_batch  i_batch,
    input  wire               i_ready,
    output logic              o_valid,
    output sdsp_pkg::t_result o_head,
    output logic              o_free
);
    import sdsp_pkg::*;

    t_result [MAX_RES-1:0] r_res;
    logic [RES_CNT_W-1:0]  r_cnt;
    logic [RES_CNT_W-1:0]  r_idx;
    logic                  take;
    logic                  take_last;

    assign o_valid   = (r_cnt != '0);
    assign o_head    = r_res[r_idx];
    assign take      = o_valid && i_ready;
    assign take_last = take && ((r_idx + RES_CNT_W'(1)) == r_cnt);
    assign o_free    = !o_valid || take_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (take_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + RES_CNT_W'(1);
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

endmodule

`default_nettype wire

// ===== design/sd_spi_command_and_block_read_core.sv =====
// SD card SPI-mode host sequencer: command frames and single-block reads.
// Slave side takes an action in tuser (start command, start block read,
// byte received) with its arguments in tdata; the master side returns words
// of kind (tuser): transmit byte, data byte, done, release select; tlast
// marks the final word caused by one input word.
// Each input word is registered, stepped through the sequencer once the
// result bank is free, and its zero to three result words are loaded into
// the result bank, which hands them out one word per cycle while the master
// side is ready. An input word is taken every cycle while its predecessor
// produced at most one result and the master side is ready, otherwise after
// the bank drains.
// A stalled master side holds the current word; the input register keeps
// one word and then drops tready until the bank frees up.
// Synchronous active-low reset returns the sequencer to idle, empties the
// result bank and sets poll_limit to 100. The user must write poll_limit via
// i_cfg_we / i_cfg_wdata only while no work is in flight; it is not enforced.
// Depends on sdsp_pkg, sdsp_seq, sdsp_out_buf.
`default_nettype none

module sd_spi_command_and_block_read_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [sdsp_pkg::POLL_W-1:0] i_cfg_wdata,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    // command_index[5:0], argument[37:6], crc_byte[45:38], flush_count[50:46],
    // sector[73:51], rx_byte[81:74], zero pad[87:82]
    input  wire [87:0] i_s_axis_tdata,
    // action[1:0]
    input  wire [1:0]  i_s_axis_tuser,
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    // tx_byte[7:0], data_byte[15:8], status[23:16], timed_out[24], zero pad[31:25]
    output logic [31:0] o_m_axis_tdata,
    // kind[1:0]
    output logic [1:0] o_m_axis_tuser,
    output logic       o_m_axis_tlast
);
    import sdsp_pkg::*;

    logic              r_in_valid;
    logic [1:0]        r_action;
    t_in_word          r_word;
    logic [POLL_W-1:0] r_poll_limit;

    logic      fire;
    logic      buf_free;
    logic      seq_idle;
    logic      in_take;
    t_batch    batch;
    t_result   head;
    t_out_word out_word;

    assign fire            = r_in_valid && buf_free;
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_poll_limit <= POLL_LIMIT_RST;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_poll_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= i_s_axis_tuser;
            r_word   <= t_in_word'(i_s_axis_tdata);
        end
    end

    sdsp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_action     (r_action),
        .i_word       (r_word),
        .i_poll_limit (r_poll_limit),
        .o_batch      (batch),
        .o_idle       (seq_idle)
    );

    sdsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_batch (batch),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head),
        .o_free  (buf_free)
    );

    always_comb begin
        out_word           = '0;
        out_word.tx_byte   = head.tx_byte;
        out_word.data_byte = head.data_byte;
        out_word.status    = head.status;
        out_word.timed_out = head.timed_out;
    end

    assign o_m_axis_tdata = out_word;
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

`ifndef SYNTHESIS
    // a done word always closes the run of results of its step
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && head.kind == KIND_DONE) |-> o_m_axis_tlast)
        else $error("done word without tlast");

    // the sequencer is idle whenever done goes out
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && head.kind == KIND_DONE) |-> seq_idle)
        else $error("done word while sequencer busy");

    // a waiting input word is never lost while the result bank is busy
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !buf_free) |=> r_in_valid)
        else $error("input word dropped");

    // only transmit words carry a byte to shift out
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && head.kind != KIND_TX) |-> head.tx_byte == 8'd0)
        else $error("tx_byte set on non-transmit word");
`endif

endmodule

`default_nettype wire

// ===== sim/sd_spi_command_and_block_read_core_test.sv =====
// Self-checking bench for the SD SPI-mode command and block-read sequencer.
// Drives command, read and received-byte words with random gaps, predicts every
// result word in its own sequencer copy, checks them in order. Needs sdsp_pkg.
module sd_spi_command_and_block_read_core_test;
    import sdsp_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int FRAME_REPLIES = 6;
    localparam int CHECK_BYTES   = 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [1:0] act;
        t_in_word   word;
    } t_host_req;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [POLL_W-1:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    t_in_word   s_word = '0;
    logic [1:0] s_act = ACT_RX;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [31:0] m_data;
    logic [1:0] m_kind;
    logic       m_last;

    sd_spi_command_and_block_read_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_word),
        .i_s_axis_tuser  (s_act),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_kind),
        .o_m_axis_tlast  (m_last)
    );

    always #10 clk = ~clk;

    t_host_req   host_reqs[$];
    t_result     awaited_words[$];
    int          idle_mode = 0;
    int          gen_limit = 100;
    int          hold_asks = 0;
    bit          word_taken = 1'b0;
    int          errors = 0;
    int          items_queued = 0;
    int          items_taken = 0;
    int          words_checked = 0;
    int          timeouts = 0;
    int          cycles = 0;

    // sequencer copy
    t_phase      sq_phase;
    bit          sq_read;
    int unsigned sq_bytes;
    int unsigned sq_pos;
    logic [POLL_W-1:0] sq_limit, sq_tries, sq_retries;
    logic [5:0]  sq_index;
    logic [31:0] sq_arg;
    logic [7:0]  sq_check;
    logic [FLUSH_W-1:0] sq_flush;
    logic [7:0]  sq_resp;

    function automatic void clear_sequencer();
        sq_phase   = PH_IDLE;
        sq_read    = 1'b0;
        sq_bytes   = 0;
        sq_pos     = 0;
        sq_limit   = POLL_LIMIT_RST;
        sq_tries   = '0;
        sq_retries = '0;
        sq_index   = '0;
        sq_arg     = '0;
        sq_check   = '0;
        sq_flush   = '0;
        sq_resp    = '0;
    endfunction

    function automatic logic [POLL_W-1:0] tries_allowed();
        return (sq_limit == '0) ? POLL_W'(1) : sq_limit;
    endfunction

    function automatic void emit_word(t_kind k, logic [7:0] tx, logic [7:0] data,
                                      logic [7:0] status, logic tmo);
        t_result w;
        w.kind      = k;
        w.tx_byte   = tx;
        w.data_byte = data;
        w.status    = status;
        w.timed_out = tmo;
        w.last      = 1'b0;
        if (k == KIND_DONE && tmo)
            timeouts++;
        awaited_words.push_back(w);
    endfunction

    function automatic logic [7:0] frame_octet(int unsigned pos);
        case (pos)
            0: return CMD_PREFIX | {2'b00, sq_index};
            1: return sq_arg[31:24];
            2: return sq_arg[23:16];
            3: return sq_arg[15:8];
            4: return sq_arg[7:0];
            default: return sq_check;
        endcase
    endfunction

    function automatic void open_frame();
        sq_phase = PH_FRAME;
        sq_pos   = 0;
        if (sq_read)
            sq_flush = FLUSH_W'(R1_FLUSH_BYTES);
        emit_word(KIND_TX, frame_octet(0), 8'h00, 8'h00, 1'b0);
    endfunction

    function automatic void close_command();
        if (!sq_read) begin
            sq_phase = PH_IDLE;
            emit_word(KIND_DONE, 8'h00, 8'h00, sq_resp, sq_resp == IDLE_BYTE);
        end else if (sq_resp == R1_OK) begin
            sq_phase = PH_TOKEN;
            sq_tries = tries_allowed();
            emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
        end else begin
            sq_retries = sq_retries - POLL_W'(1);
            if (sq_retries == '0) begin
                sq_phase = PH_IDLE;
                emit_word(KIND_DONE, 8'h00, 8'h00, sq_resp, 1'b1);
            end else begin
                open_frame();
            end
        end
    endfunction

    function automatic void close_response();
        emit_word(KIND_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0);
        if (sq_flush != '0) begin
            sq_phase = PH_FLUSH;
            emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
        end else begin
            close_command();
        end
    endfunction

    function automatic void advance_sequencer(logic [1:0] act, t_in_word w);
        int base;
        t_result tail;
        logic [7:0] rx;
        base = awaited_words.size();
        rx   = w.rx_byte;
        if ((act == ACT_CMD || act == ACT_READ) && sq_phase == PH_IDLE) begin
            if (act == ACT_CMD) begin
                sq_read  = 1'b0;
                sq_index = w.command_index;
                sq_arg   = w.argument;
                sq_check = w.crc_byte;
                sq_flush = w.flush_count;
            end else begin
                sq_read    = 1'b1;
                sq_index   = CMD_READ_1;
                sq_arg     = {w.sector, 9'd0};
                sq_check   = IDLE_BYTE;
                sq_retries = tries_allowed();
            end
            open_frame();
        end else if (act == ACT_RX) begin
            case (sq_phase)
                PH_FRAME: begin
                    if (sq_pos < 5) begin
                        sq_pos++;
                        emit_word(KIND_TX, frame_octet(sq_pos), 8'h00, 8'h00, 1'b0);
                    end else begin
                        sq_phase = PH_POLL;
                        sq_tries = tries_allowed();
                        emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                    end
                end
                PH_POLL: begin
                    sq_resp  = rx;
                    sq_tries = sq_tries - POLL_W'(1);
                    if (rx != IDLE_BYTE || sq_tries == '0)
                        close_response();
                    else
                        emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                end
                PH_FLUSH: begin
                    if (!sq_read)
                        emit_word(KIND_DATA, 8'h00, rx, 8'h00, 1'b0);
                    sq_flush = sq_flush - FLUSH_W'(1);
                    if (sq_flush != '0) begin
                        emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                    end else begin
                        emit_word(KIND_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0);
                        close_command();
                    end
                end
                PH_TOKEN: begin
                    if (rx == DATA_TOKEN) begin
                        sq_phase = PH_DATA;
                        sq_bytes = 0;
                        emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                    end else begin
                        sq_tries = sq_tries - POLL_W'(1);
                        if (sq_tries == '0) begin
                            // token never came: release select before done
                            sq_phase = PH_IDLE;
                            emit_word(KIND_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0);
                            emit_word(KIND_DONE, 8'h00, 8'h00, rx, 1'b1);
                        end else begin
                            emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                        end
                    end
                end
                PH_DATA: begin
                    emit_word(KIND_DATA, 8'h00, rx, 8'h00, 1'b0);
                    sq_bytes++;
                    if (sq_bytes >= BLOCK_BYTES) begin
                        sq_phase = PH_CRC;
                        sq_bytes = 0;
                    end
                    emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                end
                PH_CRC: begin
                    if (sq_bytes == 0) begin
                        sq_bytes = 1;
                        emit_word(KIND_TX, IDLE_BYTE, 8'h00, 8'h00, 1'b0);
                    end else begin
                        sq_phase = PH_IDLE;
                        sq_bytes = 0;
                        emit_word(KIND_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0);
                        emit_word(KIND_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
                    end
                end
                default: ;
            endcase
        end
        if (awaited_words.size() > base) begin
            tail = awaited_words.pop_back();
            tail.last = 1'b1;
            awaited_words.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // monitor: config, result check and input prediction at the rising edge
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            clear_sequencer();
            word_taken = 1'b0;
        end else begin
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                if (cfg_we)
                    sq_limit = cfg_wdata;
                if (m_valid && m_ready) begin
                    words_checked++;
                    if (awaited_words.size() == 0) begin
                        errors++;
                        $display("%0t: unexpected word, expected none, actual kind %0d data %h last %b",
                                 $time, m_kind, m_data, m_last);
                    end else begin
                        want = awaited_words.pop_front();
                        check_field("kind", 32'(want.kind), 32'(m_kind));
                        check_field("tx_byte", 32'(want.tx_byte), 32'(m_data[7:0]));
                        check_field("data_byte", 32'(want.data_byte), 32'(m_data[15:8]));
                        check_field("status", 32'(want.status), 32'(m_data[23:16]));
                        check_field("timed_out", 32'(want.timed_out), 32'(m_data[24]));
                        check_field("pad", 32'd0, 32'(m_data[31:25]));
                        check_field("last", 32'(want.last), 32'(m_last));
                    end
                end
                word_taken = s_valid && s_ready;
                if (word_taken) begin
                    items_taken++;
                    advance_sequencer(s_act, s_word);
                end
            end
        end
    end

    function automatic bit sender_rests();
        case (idle_mode)
            0: return $urandom_range(0, 99) < 9;
            1: return $urandom_range(0, 99) < 66;
            default: return 1'b0;
        endcase
    endfunction

    // driver: present the next word once the current one is taken
    always @(negedge clk) begin
        t_host_req req;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (host_reqs.size() != 0 && !sender_rests()) begin
                req = host_reqs.pop_front();
                s_valid <= 1'b1;
                s_act   <= req.act;
                s_word  <= req.word;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    int hold_left = 0;
    int holds_served = 0;
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_served != hold_asks) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (idle_mode)
                0: m_ready <= $urandom_range(0, 99) >= 66;
                1: m_ready <= $urandom_range(0, 99) >= 9;
                default: m_ready <= 1'b1;
            endcase
        end
    end

    task automatic queue_req(logic [1:0] act, logic [5:0] idx, logic [31:0] arg,
                             logic [7:0] crc, logic [4:0] fl, logic [22:0] sec,
                             logic [7:0] rx);
        t_host_req req;
        req.act                = act;
        req.word.pad           = '0;
        req.word.command_index = idx;
        req.word.argument      = arg;
        req.word.crc_byte      = crc;
        req.word.flush_count   = fl;
        req.word.sector        = sec;
        req.word.rx_byte       = rx;
        host_reqs.push_back(req);
        items_queued++;
    endtask

    task automatic queue_rx(logic [7:0] rx);
        queue_req(ACT_RX, 6'($urandom), $urandom, 8'($urandom), 5'($urandom),
                  23'($urandom), rx);
    endtask

    task automatic queue_start(logic [1:0] act);
        queue_req(act, 6'($urandom), $urandom, 8'($urandom), 5'($urandom),
                  23'($urandom), 8'($urandom));
    endtask

    function automatic int short_wait();
        return $urandom_range(0, (gen_limit > 3) ? 3 : gen_limit - 1);
    endfunction

    function automatic logic [7:0] not_token();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == DATA_TOKEN) ? IDLE_BYTE : b;
    endfunction

    // polls at or above the limit mean the card never answers
    task automatic queue_command(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc,
                                 logic [4:0] fl, int polls, logic [7:0] resp,
                                 bit busy_start);
        queue_req(ACT_CMD, idx, arg, crc, fl, 23'($urandom), 8'($urandom));
        if (busy_start)
            queue_start($urandom_range(0, 1) ? ACT_READ : ACT_CMD);
        repeat (FRAME_REPLIES) queue_rx(8'($urandom));
        repeat (polls) queue_rx(IDLE_BYTE);
        if (polls < gen_limit)
            queue_rx(resp);
        repeat (fl) queue_rx(8'($urandom));
    endtask

    task automatic queue_attempt(int polls, logic [7:0] r1);
        repeat (FRAME_REPLIES) queue_rx(8'($urandom));
        repeat (polls) queue_rx(IDLE_BYTE);
        if (polls < gen_limit)
            queue_rx(r1);
        repeat (R1_FLUSH_BYTES) queue_rx(8'($urandom));
    endtask

    task automatic queue_read(logic [22:0] sector, int bad_tries, bit token_ok);
        int tries;
        queue_req(ACT_READ, 6'($urandom), $urandom, 8'($urandom), 5'($urandom),
                  sector, 8'($urandom));
        tries = 0;
        while (tries < bad_tries && tries < gen_limit) begin
            if ($urandom_range(0, 3) == 0)
                queue_attempt(gen_limit, IDLE_BYTE);
            else
                queue_attempt(short_wait(), 8'($urandom_range(1, 254)));
            tries++;
        end
        if (bad_tries < gen_limit) begin
            queue_attempt(short_wait(), R1_OK);
            if (token_ok) begin
                repeat (short_wait()) queue_rx(not_token());
                queue_rx(DATA_TOKEN);
                repeat (BLOCK_BYTES) queue_rx(8'($urandom));
                repeat (CHECK_BYTES) queue_rx(8'($urandom));
            end else begin
                repeat (gen_limit) queue_rx(not_token());
            end
        end
    endtask

    // wait until nothing is queued, offered or awaited, and it stays that way
    task automatic wait_drained();
        forever begin
            do @(negedge clk);
            while (host_reqs.size() != 0 || s_valid || awaited_words.size() != 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (host_reqs.size() == 0 && !s_valid && awaited_words.size() == 0)
                break;
        end
        @(posedge clk);
    endtask

    // drain, then push zero bytes until the sequencer is back at idle
    task automatic settle();
        wait_drained();
        while (sq_phase != PH_IDLE) begin
            repeat (16) queue_rx(R1_OK);
            wait_drained();
        end
    endtask

    task automatic set_limit(logic [POLL_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        gen_limit = (value == '0) ? 1 : int'(value);
    endtask

    task automatic random_sequence();
        int pick;
        int polls;
        bit quiet;
        logic [7:0] resp;
        logic [4:0] fl;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            case ($urandom_range(0, 2))
                0: queue_rx(8'($urandom));
                1: queue_start(ACT_UNUSED);
                default: begin
                    // cut-off command: later starts land on a busy sequencer
                    queue_start(ACT_CMD);
                    repeat ($urandom_range(0, FRAME_REPLIES - 1)) queue_rx(8'($urandom));
                end
            endcase
        end else if (pick < 35 && gen_limit <= 8) begin
            queue_read(23'($urandom), $urandom_range(0, gen_limit), 1'b0);
        end else begin
            fl = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
            quiet = gen_limit <= 8 && $urandom_range(0, 4) == 0;
            polls = quiet ? gen_limit : short_wait();
            resp = ($urandom_range(0, 4) == 0) ? R1_OK : 8'($urandom_range(0, 254));
            queue_command(6'($urandom), $urandom, 8'($urandom), fl, polls, resp,
                          $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        int target;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 100: ignored words, both command extremes, and a long
        // receiver hold-off while the widest flush keeps words coming
        queue_rx(8'h00);
        queue_start(ACT_UNUSED);
        queue_command(6'd0, 32'h0000_0000, 8'h00, 5'd0, 0, R1_OK, 1'b0);
        hold_asks++;
        queue_command(6'd63, 32'hFFFF_FFFF, 8'hFF, 5'd31, 2, 8'h01, 1'b1);
        queue_command(6'd8, 32'h0000_01AA, 8'h87, 5'd1, 0, DATA_TOKEN, 1'b0);

        // one try: response timeout, retries used up, token timeout
        set_limit(POLL_W'(1));
        queue_command(6'($urandom), $urandom, 8'($urandom), 5'd3, gen_limit, R1_OK, 1'b0);
        queue_read(23'h7F_FFFF, 1, 1'b0);
        queue_read(23'h00_0000, 0, 1'b0);

        // zero limit behaves as one
        set_limit(POLL_W'(0));
        queue_command(6'($urandom), $urandom, 8'($urandom), 5'd0, gen_limit, R1_OK, 1'b0);

        // a read that gets through after a retry, then misses the token
        set_limit(POLL_W'(4));
        queue_read(23'($urandom), 1, 1'b0);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: set_limit(POLL_W'($urandom_range(2, 6)));
                1: set_limit(POLL_W'(1023));
                default: set_limit(POLL_W'($urandom_range(1, 3)));
            endcase
            idle_mode = mode;
            if (mode == 2)
                hold_asks++;
            target = items_queued + 5;
            while (items_queued < target)
                random_sequence();
        end
        settle();

        $display("covered %0d input words and %0d result words: commands, retried reads,",
                 items_taken, words_checked);
        $display("%0d timed-out commands or reads, poll limits from 0 to 1023", timeouts);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sd_spi_command_and_block_read_core.f =====
design/sdsp_pkg.sv
design/sdsp_seq.sv
design/sdsp_out_buf.sv
design/sd_spi_command_and_block_read_core.sv
sim/sd_spi_command_and_block_read_core_test.sv
